### rtl/core/bchd_pkg.sv
// Shared types and constants for the button click/hold detector.
`default_nettype none

package bchd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIMEOUT  = 3'd4;

  // Reset values of the configuration registers
  localparam logic                  RST_IDLE_LEVEL    = 1'b0;
  localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_MS   = 16'd80;
  localparam logic [CFG_DATA_W-1:0] RST_HOLD_TIMEOUT  = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_CLICK_TIMEOUT = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_STEP_TIMEOUT  = 16'd400;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic                  idle_level;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] hold_timeout_ms;
    logic [CFG_DATA_W-1:0] click_timeout_ms;
    logic [CFG_DATA_W-1:0] step_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic             pressed;
    logic             released;
    logic             single_release;
    logic             hold_started;
    logic             burst_done;
    logic [CNT_W-1:0] burst_clicks;
    logic             step_event;
    logic [CNT_W-1:0] step_count;
    logic             holding;
    logic [CNT_W-1:0] hold_clicks;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/bchd_if.sv
// Channel interfaces: poll input, event result and configuration write.
`default_nettype none

interface bchd_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bchd_out_if;
  logic       valid;
  logic       ready;
  logic       pressed;
  logic       released;
  logic       single_release;
  logic       hold_started;
  logic       burst_done;
  logic [7:0] burst_clicks;
  logic       step_event;
  logic [7:0] step_count;
  logic       holding;
  logic [7:0] hold_clicks;

  modport source (
    output valid, output pressed, output released, output single_release,
    output hold_started, output burst_done, output burst_clicks,
    output step_event, output step_count, output holding, output hold_clicks,
    input ready
  );
  modport sink (
    input valid, input pressed, input released, input single_release,
    input hold_started, input burst_done, input burst_clicks,
    input step_event, input step_count, input holding, input hold_clicks,
    output ready
  );
endinterface

interface bchd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/bchd_cfg_regs.sv
// Configuration register file for the click/hold detector.
`default_nettype none

module bchd_cfg_regs
  import bchd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_level       <= RST_IDLE_LEVEL;
      cfg_r.debounce_ms      <= RST_DEBOUNCE_MS;
      cfg_r.hold_timeout_ms  <= RST_HOLD_TIMEOUT;
      cfg_r.click_timeout_ms <= RST_CLICK_TIMEOUT;
      cfg_r.step_timeout_ms  <= RST_STEP_TIMEOUT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IDLE_LEVEL:    cfg_r.idle_level       <= wr_data[0];
        REG_DEBOUNCE_MS:   cfg_r.debounce_ms      <= wr_data;
        REG_HOLD_TIMEOUT:  cfg_r.hold_timeout_ms  <= wr_data;
        REG_CLICK_TIMEOUT: cfg_r.click_timeout_ms <= wr_data;
        REG_STEP_TIMEOUT:  cfg_r.step_timeout_ms  <= wr_data;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/core/bchd_engine.sv
// Button state and per-poll event logic: debounce, release, hold, burst, step.
`default_nettype none

module bchd_engine
  import bchd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic              pin_level,
  input  wire logic [TIME_W-1:0] now_ms,
  input  cfg_t                   cfg,
  output res_t                   res
);

  logic              pressed_latched_r, pressed_latched_nxt;
  logic              debounce_pending_r, debounce_pending_nxt;
  logic [TIME_W-1:0] mark_time_r, mark_time_nxt;
  logic [CNT_W-1:0]  click_count_r, click_count_nxt;
  logic [CNT_W-1:0]  clicks_before_hold_r, clicks_before_hold_nxt;
  logic              hold_active_r, hold_active_nxt;
  logic              step_active_r, step_active_nxt;
  logic              single_pending_r, single_pending_nxt;

  // One subtractor against the stored mark; once a rule moves the mark to
  // now, later rules in the same poll see zero elapsed time.
  logic [TIME_W-1:0] elapsed;
  assign elapsed = now_ms - mark_time_r;

  always_comb begin
    logic              down;
    logic              mark_now;
    logic [TIME_W-1:0] el;
    logic              pl, dp, ha, sa, sp;
    logic [CNT_W-1:0]  cc, cbh;

    down     = pin_level ^ cfg.idle_level;
    mark_now = 1'b0;
    pl  = pressed_latched_r;
    dp  = debounce_pending_r;
    ha  = hold_active_r;
    sa  = step_active_r;
    sp  = single_pending_r;
    cc  = click_count_r;
    cbh = clicks_before_hold_r;
    res = '0;

    // press debounce
    if (down && !pl) begin
      if (!dp) begin
        dp       = 1'b1;
        mark_now = 1'b1;
      end else if (elapsed >= TIME_W'(cfg.debounce_ms)) begin
        pl          = 1'b1;
        sp          = 1'b1;
        res.pressed = 1'b1;
      end
    end else begin
      dp = 1'b0;
    end

    // release
    if (!down && pl) begin
      pl = 1'b0;
      if (!ha && cc != CNT_MAX) cc = cc + CNT_W'(1);
      ha           = 1'b0;
      res.released = 1'b1;
      mark_now     = 1'b1;
      if (sa) begin
        cc = '0;
        sa = 1'b0;
      end
      if (sp) begin
        sp                 = 1'b0;
        res.single_release = 1'b1;
      end
    end

    // hold start
    el = mark_now ? '0 : elapsed;
    if (pl && down && !ha && el >= TIME_W'(cfg.hold_timeout_ms)) begin
      ha               = 1'b1;
      sa               = 1'b1;
      sp               = 1'b0;
      cbh              = cc;
      mark_now         = 1'b1;
      res.hold_started = 1'b1;
    end

    // burst close
    el = mark_now ? '0 : elapsed;
    if (!down && cc != '0 && el >= TIME_W'(cfg.click_timeout_ms)) begin
      res.burst_done   = 1'b1;
      res.burst_clicks = cc;
      cc               = '0;
    end

    // step repeat
    el = mark_now ? '0 : elapsed;
    if (sa && el >= TIME_W'(cfg.step_timeout_ms)) begin
      mark_now       = 1'b1;
      res.step_event = 1'b1;
      res.step_count = cc;
    end

    res.holding     = ha | sa;
    res.hold_clicks = ha ? cbh : '0;

    pressed_latched_nxt    = pl;
    debounce_pending_nxt   = dp;
    mark_time_nxt          = mark_now ? now_ms : mark_time_r;
    click_count_nxt        = cc;
    clicks_before_hold_nxt = cbh;
    hold_active_nxt        = ha;
    step_active_nxt        = sa;
    single_pending_nxt     = sp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_latched_r    <= 1'b0;
      debounce_pending_r   <= 1'b0;
      mark_time_r          <= '0;
      click_count_r        <= '0;
      clicks_before_hold_r <= '0;
      hold_active_r        <= 1'b0;
      step_active_r        <= 1'b0;
      single_pending_r     <= 1'b0;
    end else if (step_en) begin
      pressed_latched_r    <= pressed_latched_nxt;
      debounce_pending_r   <= debounce_pending_nxt;
      mark_time_r          <= mark_time_nxt;
      click_count_r        <= click_count_nxt;
      clicks_before_hold_r <= clicks_before_hold_nxt;
      hold_active_r        <= hold_active_nxt;
      step_active_r        <= step_active_nxt;
      single_pending_r     <= single_pending_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/button_click_hold_detector.sv
// Top level of the push-button click/hold detector.
`default_nettype none

// Each input transaction is one poll of a push button (raw pin level plus a
// wrapping millisecond timestamp) and yields exactly one result transaction
// carrying that poll's event pulses (press, release, single release, hold
// start, burst close with its click count, step repeat with its count) and
// the holding level. The button is down when the pin differs from the
// configured idle level; all elapsed times are 32-bit wrapping differences.
// Throughput is one poll per clock while results are taken: a poll sits in
// an input register, the event logic (one 32-bit subtract and four 32-bit
// threshold compares against 16-bit settings) runs in the cycle it moves to
// the output register, and the button state is updated in that same cycle,
// so polls stream back to back. A poll passes through the input register and
// then the output register before its result is presented. While a result
// waits, a new poll is still taken if the input register is empty.
// Configuration writes are taken in any cycle (cfg_chan.ready is tied high)
// and must only be issued while no poll is in flight; unknown register
// indexes are ignored.
module button_click_hold_detector
  import bchd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  bchd_in_if.sink   in_chan,
  bchd_out_if.source out_chan,
  bchd_cfg_if.sink  cfg_chan
);

  cfg_t cfg;
  res_t res;

  // Input register
  logic              in_valid_r;
  logic              pin_r;
  logic [TIME_W-1:0] now_r;

  // Output register
  logic out_valid_r;
  res_t res_r;

  logic advance;

  // A poll moves from the input to the output register when the output
  // slot is empty or its result is being taken this cycle.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  bchd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  bchd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .pin_level (pin_r),
    .now_ms    (now_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      pin_r <= in_chan.pin_level;
      now_r <= in_chan.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.pressed        = res_r.pressed;
  assign out_chan.released       = res_r.released;
  assign out_chan.single_release = res_r.single_release;
  assign out_chan.hold_started   = res_r.hold_started;
  assign out_chan.burst_done     = res_r.burst_done;
  assign out_chan.burst_clicks   = res_r.burst_clicks;
  assign out_chan.step_event     = res_r.step_event;
  assign out_chan.step_count     = res_r.step_count;
  assign out_chan.holding        = res_r.holding;
  assign out_chan.hold_clicks    = res_r.hold_clicks;

endmodule

`default_nettype wire

### rtl/core/bchd_checker.sv
// Port-level assertions for the click/hold detector, bound to the top level.
`default_nettype none

module bchd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       pressed,
  input wire logic       released,
  input wire logic       single_release,
  input wire logic       burst_done,
  input wire logic [7:0] burst_clicks,
  input wire logic       step_event,
  input wire logic [7:0] step_count,
  input wire logic       holding,
  input wire logic [7:0] hold_clicks
);

  // Stalled result holds valid, its press and release bits and its counts
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pressed) && $stable(released)
      && $stable(burst_clicks) && $stable(step_count))
    else $error("result changed while stalled");

  // A poll is either down or up, so press and release never share a result
  a_press_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(pressed && released))
    else $error("press and release in one result");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && single_release |-> released)
    else $error("single release without release");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (burst_done || burst_clicks == 8'd0) && (step_event || step_count == 8'd0))
    else $error("click count without its event");

  a_hold_clicks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !holding |-> hold_clicks == 8'd0 && !step_event)
    else $error("hold data outside of hold");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .pressed        (out_chan.pressed),
  .released       (out_chan.released),
  .single_release (out_chan.single_release),
  .burst_done     (out_chan.burst_done),
  .burst_clicks   (out_chan.burst_clicks),
  .step_event     (out_chan.step_event),
  .step_count     (out_chan.step_count),
  .holding        (out_chan.holding),
  .hold_clicks    (out_chan.hold_clicks)
);

`default_nettype wire
